// File: hdl/assert_macros.svh
// Assertion macros used by the deframer core RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk and disabled while reset is low.
`define YBD_ASSERT_IMP(lbl, pre, con) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (con)) \
        else $error("deframer assertion failed");

// Next-cycle implication, sampled on i_clk and disabled while reset is low.
`define YBD_ASSERT_NXT(lbl, pre, con) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (con)) \
        else $error("deframer assertion failed");

`endif

// File: hdl/ybd_pkg.sv
// Types, codes and the CRC-16/XMODEM byte update for the YMODEM block deframer.
`default_nettype none

package ybd_pkg;

    // Parser phase codes.
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_CAN   = 2'd1;
    localparam logic [1:0] PH_BLOCK = 2'd2;

    // Result event codes.
    localparam logic [2:0] EV_DATA   = 3'd0;
    localparam logic [2:0] EV_GOOD   = 3'd1;
    localparam logic [2:0] EV_EOT    = 3'd2;
    localparam logic [2:0] EV_CANCEL = 3'd3;
    localparam logic [2:0] EV_ABORT  = 3'd4;
    localparam logic [2:0] EV_ERROR  = 3'd5;

    // Control bytes of the protocol.
    localparam logic [7:0] BYTE_SOH     = 8'h01;
    localparam logic [7:0] BYTE_STX     = 8'h02;
    localparam logic [7:0] BYTE_EOT     = 8'h04;
    localparam logic [7:0] BYTE_CA      = 8'h18;
    localparam logic [7:0] BYTE_ABORT_U = 8'h41;
    localparam logic [7:0] BYTE_ABORT_L = 8'h61;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Byte counts measured from the sequence byte: the last payload byte sits at
    // block size plus one, the CRC high byte at block size plus two.
    localparam logic [10:0] LAST_DATA_SMALL = 11'd129;
    localparam logic [10:0] LAST_DATA_LARGE = 11'd1025;
    localparam logic [10:0] CRC_HI_SMALL    = 11'd130;
    localparam logic [10:0] CRC_HI_LARGE    = 11'd1026;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } t_in_beat;

    typedef struct packed {
        logic [2:0] event_res;
        logic [7:0] data_byte;
        logic [9:0] byte_index;
        logic [7:0] seq_number;
        logic       large_block;
        logic       crc_match;
    } t_out_beat;

    typedef struct packed {
        logic      valid;
        t_out_beat beat;
    } t_step_res;

    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: hdl/ybd_parser.sv
// Frame parser: holds the block state and turns one input beat into at most one result.
`default_nettype none

module ybd_parser (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_step,
    input  wire ybd_pkg::t_in_beat i_beat,
    output ybd_pkg::t_step_res  o_res
);
    import ybd_pkg::*;

    logic [1:0]  r_phase, n_phase;
    logic        r_large, n_large;
    logic [10:0] r_count, n_count;
    logic [7:0]  r_seq, n_seq;
    logic [7:0]  r_seq_cpl, n_seq_cpl;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_crc_hi, n_crc_hi;

    logic [10:0] w_last_data;
    logic [10:0] w_crc_hi_pos;
    logic [10:0] w_index;
    logic [7:0]  w_b;

    assign w_b          = i_beat.rx_byte;
    assign w_last_data  = r_large ? LAST_DATA_LARGE : LAST_DATA_SMALL;
    assign w_crc_hi_pos = r_large ? CRC_HI_LARGE : CRC_HI_SMALL;
    assign w_index      = r_count - 11'd2;

    always_comb begin
        n_phase   = r_phase;
        n_large   = r_large;
        n_count   = r_count;
        n_seq     = r_seq;
        n_seq_cpl = r_seq_cpl;
        n_crc     = r_crc;
        n_crc_hi  = r_crc_hi;
        o_res     = '0;

        if (i_beat.action) begin
            n_phase               = PH_IDLE;
            o_res.valid           = 1'b1;
            o_res.beat.event_res  = EV_ERROR;
        end else begin
            case (r_phase)
                PH_CAN: begin
                    n_phase              = PH_IDLE;
                    o_res.valid          = 1'b1;
                    o_res.beat.event_res = (w_b == BYTE_CA) ? EV_CANCEL : EV_ERROR;
                end
                PH_BLOCK: begin
                    n_count = r_count + 11'd1;
                    if (r_count == 11'd0) begin
                        n_seq = w_b;
                    end else if (r_count == 11'd1) begin
                        n_seq_cpl = w_b;
                    end else if (r_count <= w_last_data) begin
                        n_crc                  = crc16_update(r_crc, w_b);
                        o_res.valid            = 1'b1;
                        o_res.beat.event_res   = EV_DATA;
                        o_res.beat.data_byte   = w_b;
                        o_res.beat.byte_index  = w_index[9:0];
                        o_res.beat.large_block = r_large;
                    end else if (r_count == w_crc_hi_pos) begin
                        n_crc_hi = w_b;
                    end else begin
                        n_phase                = PH_IDLE;
                        o_res.valid            = 1'b1;
                        o_res.beat.event_res   = (r_seq == ~r_seq_cpl) ? EV_GOOD : EV_ERROR;
                        o_res.beat.seq_number  = r_seq;
                        o_res.beat.large_block = r_large;
                        o_res.beat.crc_match   = ({r_crc_hi, w_b} == r_crc);
                    end
                end
                default: begin
                    // Idle; the unused phase code behaves the same way.
                    n_phase = PH_IDLE;
                    case (w_b)
                        BYTE_SOH, BYTE_STX: begin
                            n_large   = (w_b == BYTE_STX);
                            n_phase   = PH_BLOCK;
                            n_count   = '0;
                            n_seq     = '0;
                            n_seq_cpl = '0;
                            n_crc     = '0;
                            n_crc_hi  = '0;
                        end
                        BYTE_EOT: begin
                            o_res.valid          = 1'b1;
                            o_res.beat.event_res = EV_EOT;
                        end
                        BYTE_CA: begin
                            n_phase = PH_CAN;
                        end
                        BYTE_ABORT_U, BYTE_ABORT_L: begin
                            o_res.valid          = 1'b1;
                            o_res.beat.event_res = EV_ABORT;
                        end
                        default: begin
                            o_res.valid          = 1'b1;
                            o_res.beat.event_res = EV_ERROR;
                        end
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_large   <= 1'b0;
            r_count   <= '0;
            r_seq     <= '0;
            r_seq_cpl <= '0;
            r_crc     <= '0;
            r_crc_hi  <= '0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_large   <= n_large;
            r_count   <= n_count;
            r_seq     <= n_seq;
            r_seq_cpl <= n_seq_cpl;
            r_crc     <= n_crc;
            r_crc_hi  <= n_crc_hi;
        end
    end

endmodule

`default_nettype wire

// File: hdl/ymodem_block_deframer_core.sv
// YMODEM block deframer top level: input register, frame parser and result register.
//
// Input channel (i_in_valid / o_in_ready / i_in_beat) carries one beat per received
// UART byte or receive timeout. Output channel (o_out_valid / i_out_ready / o_out_beat)
// carries the results: payload bytes with their index, block verdicts with the
// sequence number and a CRC-16/XMODEM match flag, and EOT, cancel, abort or error.
// Start bytes, the first CA, the sequence byte, its complement and the CRC high byte
// produce no beat on the output.
// Path: each input beat is captured in the input register, stepped through the parser,
// and its result is captured in the result register, which drives the output.
// Throughput: one input beat per cycle while the receiver takes results; the parser
// step is a single pass through the CRC byte update and compares, so nothing iterates.
// When the receiver stalls, the result register holds its beat, the input register
// holds the next one, and o_in_ready drops once both are full.
// Reset (i_rst_n low, synchronous) empties both registers and returns the parser to
// idle with its block state cleared.
`default_nettype none

module ymodem_block_deframer_core (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire ybd_pkg::t_in_beat i_in_beat,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output ybd_pkg::t_out_beat  o_out_beat
);
    import ybd_pkg::*;

`include "assert_macros.svh"

    logic      r_in_valid;
    t_in_beat  r_in_beat;
    logic      r_out_valid;
    t_out_beat r_out_beat;

    logic      w_advance;
    logic      w_step;
    t_step_res w_res;

    // The result register can take a new beat when it is empty or being drained.
    assign w_advance  = !r_out_valid || i_out_ready;
    assign w_step     = r_in_valid && w_advance;
    assign o_in_ready = !r_in_valid || w_advance;

    ybd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_beat  (r_in_beat),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= w_step && w_res.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_beat <= i_in_beat;
        end
        if (w_step && w_res.valid) begin
            r_out_beat <= w_res.beat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    `YBD_ASSERT_IMP(a_event_code_range, o_out_valid, o_out_beat.event_res <= EV_ERROR)
    `YBD_ASSERT_IMP(a_data_has_no_verdict,
                    o_out_valid && o_out_beat.event_res == EV_DATA,
                    o_out_beat.seq_number == 8'd0 && !o_out_beat.crc_match)
    `YBD_ASSERT_IMP(a_full_pipe_blocks_input,
                    r_in_valid && r_out_valid && !i_out_ready, !o_in_ready)
    `YBD_ASSERT_NXT(a_stalled_result_held,
                    r_out_valid && !i_out_ready, r_out_valid && $stable(r_out_beat))

endmodule

`default_nettype wire
